/* rtl/add_sub_paren_expression_eval_core_assert.svh */
// Assertion macros for the expression evaluator core.
`ifndef ADD_SUB_PAREN_EXPRESSION_EVAL_CORE_ASSERT_SVH
`define ADD_SUB_PAREN_EXPRESSION_EVAL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ASPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASPE_ASSERT(lbl, prop, msg)
`define ASPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/aspe_pkg.sv */
// Shared types, codes and helpers of the expression evaluator.
`default_nettype none
package aspe_pkg;

  localparam int MAX_NEST_DEF = 32;
  localparam int SUM_W        = 32;
  localparam int EXT_W        = SUM_W + 2;
  localparam int FRAME_W      = SUM_W + 1;

  typedef logic [2:0]              status_t;
  typedef logic [7:0]              char_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [EXT_W-1:0] ext_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_CLOSE      = 3'd1;
  localparam status_t ST_OPEN_MINUS = 3'd2;
  localparam status_t ST_DEEP       = 3'd3;
  localparam status_t ST_OVF        = 3'd4;

  localparam char_t CH_OPEN  = 8'h28;
  localparam char_t CH_CLOSE = 8'h29;
  localparam char_t CH_MINUS = 8'h2d;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  // state handed to the finishing stage on the final character
  typedef struct packed {
    sum_t         cur;
    logic [31:0]  acc;
    logic         in_num;
    logic         pm;
    logic         open;
    status_t      err;
  } snap_t;

  function automatic ext_t sext(input sum_t v);
    return {{2{v[SUM_W-1]}}, v};
  endfunction

  // true when a 34-bit sum no longer fits 32-bit signed
  function automatic logic out_of_range(input ext_t s);
    return !(s[EXT_W-1:SUM_W-1] == 3'b000 || s[EXT_W-1:SUM_W-1] == 3'b111);
  endfunction

endpackage
`default_nettype wire

/* rtl/aspe_if.sv */
// Character request channel and result channel.
`default_nettype none
interface aspe_in_if;
  import aspe_pkg::*;
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last;
  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

interface aspe_out_if;
  import aspe_pkg::*;
  logic    valid;
  logic    ready;
  sum_t    value;
  status_t status;
  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

/* rtl/aspe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module aspe_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

/* rtl/add_sub_paren_expression_eval_core.sv */
// Top level of the streaming +/- parenthesized expression evaluator.
//
// Takes one character per cycle, back to back unless stalled, and returns one result
// (value and status) per expression through the finishing and output registers
// once its final character is accepted. Per nesting level the outer sum and pending
// minus sit in a MAX_NEST x 33-bit stack RAM; the next read address is driven from
// the next depth so the top entry is ready on the cycle after any push or pop, and
// a push forwards its own data to the following cycle. Stack entries need no
// clearing; the block is ready right after reset. The final-character stage and the
// output register let a new expression start while a result waits.
`default_nettype none
`include "add_sub_paren_expression_eval_core_assert.svh"
module add_sub_paren_expression_eval_core #(
  parameter int MAX_NEST = aspe_pkg::MAX_NEST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  aspe_in_if.sink     in_chan,
  aspe_out_if.source  out_chan
);
  import aspe_pkg::*;

  localparam int DW = $clog2(MAX_NEST + 1);
  localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam logic [35:0] NUM_LIM = 36'h0_8000_0000;

  // character stage state
  sum_t          cur_r, cur_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          in_num_r, in_num_nxt;
  logic          pm_r, pm_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  status_t       err_r, err_nxt;

  // finishing stage and output register
  logic    fin_v_r;
  snap_t   fin_r, snap;
  logic    out_v_r;
  sum_t    out_val_r;
  status_t out_st_r;

  // stack memory access
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [FRAME_W-1:0] mem_wdata, mem_rdata, frame;
  logic               fwd_r;
  logic [FRAME_W-1:0] fwd_data_r;
  logic [DW-1:0]      rd_depth;

  logic        out_free, fin_free, acc_item, fin_load;
  logic        is_digit, dig_ovf, fin1_ovf, pm1, top_neg;
  logic [7:0]  dig8;
  logic [35:0] acc_x10;
  ext_t        sum_fin, s2, fsum;
  sum_t        s1, top_sum;
  status_t     f_st;
  sum_t        f_val;

  assign out_free      = !out_v_r || out_chan.ready;
  assign fin_free      = !fin_v_r || out_free;
  assign in_chan.ready = fin_free;
  assign acc_item      = in_chan.valid && fin_free;
  assign fin_load      = acc_item && in_chan.last;

  assign is_digit = (in_chan.char_code >= CH_ZERO) && (in_chan.char_code <= CH_NINE);
  assign dig8     = in_chan.char_code - CH_ZERO;
  assign acc_x10  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, dig8[3:0]};
  assign dig_ovf  = acc_x10 > NUM_LIM;

  // close off a digit run ahead of a non-digit
  assign sum_fin  = pm_r ? sext(cur_r) - {2'b00, acc_r} : sext(cur_r) + {2'b00, acc_r};
  assign fin1_ovf = in_num_r && out_of_range(sum_fin);
  assign s1       = in_num_r ? sum_fin[SUM_W-1:0] : cur_r;
  assign pm1      = in_num_r ? 1'b0 : pm_r;

  assign frame   = fwd_r ? fwd_data_r : mem_rdata;
  assign top_neg = frame[FRAME_W-1];
  assign top_sum = frame[SUM_W-1:0];
  assign s2      = top_neg ? sext(top_sum) - sext(s1) : sext(top_sum) + sext(s1);

  always_comb begin
    cur_nxt    = cur_r;
    acc_nxt    = acc_r;
    in_num_nxt = in_num_r;
    pm_nxt     = pm_r;
    depth_nxt  = depth_r;
    err_nxt    = err_r;
    mem_we     = 1'b0;
    mem_waddr  = depth_r[AW-1:0];
    mem_wdata  = {pm1, s1};
    if (acc_item && err_r == ST_OK) begin
      if (is_digit) begin
        if (dig_ovf) begin
          err_nxt = ST_OVF;
        end else begin
          acc_nxt    = acc_x10[31:0];
          in_num_nxt = 1'b1;
        end
      end else begin
        in_num_nxt = 1'b0;
        acc_nxt    = '0;
        cur_nxt    = s1;
        pm_nxt     = pm1;
        if (fin1_ovf) begin
          err_nxt = ST_OVF;
        end else begin
          case (in_chan.char_code)
            CH_OPEN: begin
              if (depth_r == DW'(MAX_NEST)) begin
                err_nxt = ST_DEEP;
              end else begin
                mem_we    = 1'b1;
                depth_nxt = depth_r + DW'(1);
                cur_nxt   = '0;
                pm_nxt    = 1'b0;
              end
            end
            CH_CLOSE: begin
              if (depth_r == '0) begin
                err_nxt = ST_CLOSE;
              end else if (pm1) begin
                err_nxt = ST_OPEN_MINUS;
              end else begin
                depth_nxt = depth_r - DW'(1);
                pm_nxt    = 1'b0;
                if (out_of_range(s2)) begin
                  err_nxt = ST_OVF;
                end else begin
                  cur_nxt = s2[SUM_W-1:0];
                end
              end
            end
            CH_MINUS: begin
              if (pm1) begin
                err_nxt = ST_OPEN_MINUS;
              end else begin
                pm_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end
    snap = '{cur: cur_nxt, acc: acc_nxt, in_num: in_num_nxt, pm: pm_nxt,
             open: (depth_nxt != '0), err: err_nxt};
    if (fin_load) begin
      cur_nxt    = '0;
      acc_nxt    = '0;
      in_num_nxt = 1'b0;
      pm_nxt     = 1'b0;
      depth_nxt  = '0;
      err_nxt    = ST_OK;
    end
  end

  // prefetch the entry that will be on top next cycle
  assign rd_depth  = depth_nxt - DW'(1);
  assign mem_raddr = rd_depth[AW-1:0];

  aspe_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (MAX_NEST)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // finishing stage: last digit run, open/minus check, status
  always_comb begin
    fsum = fin_r.pm ? sext(fin_r.cur) - {2'b00, fin_r.acc}
                    : sext(fin_r.cur) + {2'b00, fin_r.acc};
    if (fin_r.err != ST_OK) begin
      f_st = fin_r.err;
    end else if (fin_r.in_num && out_of_range(fsum)) begin
      f_st = ST_OVF;
    end else if (fin_r.open || (fin_r.pm && !fin_r.in_num)) begin
      f_st = ST_OPEN_MINUS;
    end else begin
      f_st = ST_OK;
    end
    if (f_st != ST_OK) begin
      f_val = '0;
    end else if (fin_r.in_num) begin
      f_val = fsum[SUM_W-1:0];
    end else begin
      f_val = fin_r.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      acc_r    <= '0;
      in_num_r <= 1'b0;
      pm_r     <= 1'b0;
      depth_r  <= '0;
      err_r    <= ST_OK;
      fin_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      cur_r    <= cur_nxt;
      acc_r    <= acc_nxt;
      in_num_r <= in_num_nxt;
      pm_r     <= pm_nxt;
      depth_r  <= depth_nxt;
      err_r    <= err_nxt;
      if (fin_free) begin
        fin_v_r <= fin_load;
      end
      if (out_free) begin
        out_v_r <= fin_v_r;
      end
      fwd_r <= mem_we && (mem_waddr == mem_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_r <= snap;
    end
    if (out_free && fin_v_r) begin
      out_val_r <= f_val;
      out_st_r  <= f_st;
    end
    fwd_data_r <= mem_wdata;
  end

  assign out_chan.valid  = out_v_r;
  assign out_chan.value  = out_val_r;
  assign out_chan.status = out_st_r;

  `ASPE_ASSERT(a_depth_bound, depth_r <= DW'(MAX_NEST), "nesting depth beyond stack size")
  `ASPE_ASSERT(a_push_clean, mem_we |-> (err_r == ST_OK && depth_r < DW'(MAX_NEST)), "push while in error or full")
  `ASPE_ASSERT_NEXT(a_push_fwd, mem_we && !fin_load, frame == $past(mem_wdata), "pushed frame not on top")
  `ASPE_ASSERT_NEXT(a_last_clear, fin_load, fin_v_r && depth_r == '0 && err_r == ST_OK, "state not cleared after final character")
  `ASPE_ASSERT(a_err_zero, (out_v_r && out_st_r != ST_OK) |-> out_val_r == '0, "nonzero value with error status")
endmodule
`default_nettype wire
